### rtl/brf_pkg.sv
// Shared types and constants of the circular byte FIFO.
package brf_pkg;

  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned MAX_BYTES_DEF = 8;
  localparam int unsigned LANES         = 8;
  localparam int unsigned LANE_W        = 3;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned S_DATA_W      = ((COUNT_W + DATA_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_e;

  typedef struct packed {
    logic              show;
    logic [LANE_W-1:0] lo;
    logic [COUNT_W-1:0] n;
  } merge_ctl_t;

endpackage

### rtl/brf_bank.sv
// One byte-wide bank of the store: single port, registered read data.
module brf_bank #(
  parameter int unsigned ROWS  = 32,
  parameter int unsigned ROW_W = 5
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[row_i] <= wdata_i;
      end
      rdata_q <= mem_q[row_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/brf_merge.sv
// Merge stage: rotate bank outputs into arrival order, mask unused bytes, register.
module brf_merge (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  brf_pkg::merge_ctl_t                     ctl_i,
  input  logic [brf_pkg::LANES-1:0][7:0]          lanes_i,
  output logic [brf_pkg::DATA_W-1:0]              bytes_o
);

  logic [brf_pkg::DATA_W-1:0] bytes_d;
  logic [brf_pkg::DATA_W-1:0] bytes_q;

  always_comb begin
    logic [brf_pkg::LANE_W-1:0] src;
    bytes_d = '0;
    for (int i = 0; i < int'(brf_pkg::LANES); i++) begin
      src = brf_pkg::LANE_W'(i) + ctl_i.lo;
      if (ctl_i.show && (brf_pkg::COUNT_W'(i) < ctl_i.n)) begin
        bytes_d[i*8 +: 8] = lanes_i[src];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= bytes_d;
    end
  end

  assign bytes_o = bytes_q;

endmodule

### rtl/byte_ring_fifo_multi_access.sv
// Top level of the circular byte FIFO with multi-byte requests.
//
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   byte_count[3:0], write_bytes[67:4], pad    req_type[1:0]
// m_axis   out  read_bytes[63:0], stored_count, pad        accepted[0]
//
// On a request's accept edge the positions update and all eight banks are
// driven at once; the next edge loads the merged result. No new request is
// taken while one is still in flight, even when the output drains freely.
// The output register holds a result under back-pressure; no request is
// taken until it leaves. Reset clears only positions, fill count, busy and valid.
// CAPACITY must be a multiple of eight (one row across the eight banks).
module byte_ring_fifo_multi_access #(
  parameter  int unsigned CAPACITY             = brf_pkg::CAPACITY_DEF,
  parameter  int unsigned MAX_BYTES_PER_ACCESS = brf_pkg::MAX_BYTES_DEF,
  localparam int unsigned CNT_W                = $clog2(CAPACITY + 1),
  localparam int unsigned M_DATA_W             = ((brf_pkg::DATA_W + CNT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [brf_pkg::S_DATA_W-1:0] s_axis_tdata,  // byte_count, write_bytes
  input  logic [1:0]                   s_axis_tuser,  // req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [M_DATA_W-1:0]          m_axis_tdata,  // read_bytes, stored_count
  output logic [0:0]                   m_axis_tuser   // accepted
);

  localparam int unsigned ROWS  = CAPACITY / brf_pkg::LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LW    = brf_pkg::LANE_W;
  localparam int unsigned NW    = brf_pkg::COUNT_W;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    if (r == ROW_W'(ROWS - 1)) begin
      return '0;
    end
    return r + 1'b1;
  endfunction

  brf_pkg::req_kind_e             kind;
  logic [NW-1:0]                  n;
  logic [brf_pkg::DATA_W-1:0]     wbytes;
  logic                           accept;
  logic                           count_ok;
  logic                           ok;
  logic [CNT_W:0]                 sum_wr;
  logic                           wr_fits;
  logic                           rd_fits;
  logic                           is_wr;
  logic                           is_rd;
  logic                           load;

  logic [ROW_W-1:0] rd_row_q, rd_row_d, wr_row_q, wr_row_d;
  logic [LW-1:0]    rd_lo_q, rd_lo_d, wr_lo_q, wr_lo_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             busy_q, out_valid_q;
  logic             ok_q, out_ok_q;
  logic [CNT_W-1:0] cnt_q, out_cnt_q;
  brf_pkg::merge_ctl_t ctl_q;

  logic [ROW_W-1:0] base_row, base_row_inc;
  logic [LW-1:0]    base_lo;
  logic [LW:0]      lo_sum;
  logic [ROW_W-1:0] lane_row [brf_pkg::LANES];
  logic [brf_pkg::LANES-1:0] lane_we;
  logic [brf_pkg::LANES-1:0][7:0] lane_wdata;
  logic [brf_pkg::LANES-1:0][7:0] lane_rdata;
  logic [brf_pkg::DATA_W-1:0] merged;

  assign kind   = brf_pkg::req_kind_e'(s_axis_tuser);
  assign n      = s_axis_tdata[NW-1:0];
  assign wbytes = s_axis_tdata[NW +: brf_pkg::DATA_W];

  assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = busy_q;

  assign count_ok = (n != '0) && (int'(n) <= int'(MAX_BYTES_PER_ACCESS));
  assign sum_wr   = (CNT_W + 1)'(fill_q) + (CNT_W + 1)'(n);
  assign wr_fits  = sum_wr <= (CNT_W + 1)'(CAPACITY);
  assign rd_fits  = (CNT_W + 1)'(n) <= (CNT_W + 1)'(fill_q);
  assign is_wr    = (kind == brf_pkg::REQ_WRITE);
  assign is_rd    = (kind == brf_pkg::REQ_READ) || (kind == brf_pkg::REQ_PEEK);

  always_comb begin
    unique case (kind)
      brf_pkg::REQ_WRITE: ok = count_ok && wr_fits;
      brf_pkg::REQ_READ:  ok = count_ok && rd_fits;
      brf_pkg::REQ_PEEK:  ok = count_ok && rd_fits;
      brf_pkg::REQ_CLEAR: ok = 1'b1;
      default:            ok = 1'b0;
    endcase
  end

  // bank addressing: byte i of the request lands in bank (lo + i) mod 8
  assign base_row     = is_wr ? wr_row_q : rd_row_q;
  assign base_lo      = is_wr ? wr_lo_q : rd_lo_q;
  assign base_row_inc = row_inc(base_row);
  assign lo_sum       = (LW + 1)'(base_lo) + (LW + 1)'(n);

  always_comb begin
    logic [LW-1:0] off;
    for (int k = 0; k < int'(brf_pkg::LANES); k++) begin
      off           = LW'(k) - base_lo;
      lane_row[k]   = (LW'(k) < base_lo) ? base_row_inc : base_row;
      lane_we[k]    = accept && is_wr && ok && ((NW)'(off) < n);
      lane_wdata[k] = wbytes[off*8 +: 8];
    end
  end

  always_comb begin
    rd_row_d = rd_row_q;
    rd_lo_d  = rd_lo_q;
    wr_row_d = wr_row_q;
    wr_lo_d  = wr_lo_q;
    fill_d   = fill_q;
    unique case (kind)
      brf_pkg::REQ_WRITE: begin
        if (ok) begin
          wr_lo_d  = lo_sum[LW-1:0];
          wr_row_d = lo_sum[LW] ? base_row_inc : base_row;
          fill_d   = sum_wr[CNT_W-1:0];
        end
      end
      brf_pkg::REQ_READ: begin
        if (ok) begin
          rd_lo_d  = lo_sum[LW-1:0];
          rd_row_d = lo_sum[LW] ? base_row_inc : base_row;
          fill_d   = fill_q - CNT_W'(n);
        end
      end
      brf_pkg::REQ_PEEK: begin
      end
      brf_pkg::REQ_CLEAR: begin
        rd_row_d = '0;
        rd_lo_d  = '0;
        wr_row_d = '0;
        wr_lo_d  = '0;
        fill_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_row_q    <= '0;
      rd_lo_q     <= '0;
      wr_row_q    <= '0;
      wr_lo_q     <= '0;
      fill_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_row_q <= rd_row_d;
        rd_lo_q  <= rd_lo_d;
        wr_row_q <= wr_row_d;
        wr_lo_q  <= wr_lo_d;
        fill_q   <= fill_d;
      end
      busy_q <= accept;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q.show <= ok && is_rd;
      ctl_q.lo   <= rd_lo_q;
      ctl_q.n    <= n;
      ok_q       <= ok;
      cnt_q      <= fill_d;
    end
    if (load) begin
      out_ok_q  <= ok_q;
      out_cnt_q <= cnt_q;
    end
  end

  for (genvar g = 0; g < int'(brf_pkg::LANES); g++) begin : g_bank
    brf_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (accept),
      .we_i    (lane_we[g]),
      .row_i   (lane_row[g]),
      .wdata_i (lane_wdata[g]),
      .rdata_o (lane_rdata[g])
    );
  end

  brf_merge u_merge (
    .clk_i   (clk_i),
    .load_i  (load),
    .ctl_i   (ctl_q),
    .lanes_i (lane_rdata),
    .bytes_o (merged)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({out_cnt_q, merged});
  assign m_axis_tuser  = out_ok_q;

endmodule

### rtl/brf_checker.sv
// Port-level checker of the circular byte FIFO and its bind.
module brf_checker #(
  parameter int unsigned CNT_W    = 9,
  parameter int unsigned M_DATA_W = 80
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [brf_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic [1:0]                   s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [M_DATA_W-1:0]          m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while previous still in flight");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[brf_pkg::DATA_W-1:0] == '0)
    else $error("refused request returned bytes");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == brf_pkg::REQ_CLEAR) |-> ##2
      m_axis_tvalid && m_axis_tuser[0] &&
      (m_axis_tdata[brf_pkg::DATA_W +: CNT_W] == '0))
    else $error("clear did not empty the store");

  a_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == brf_pkg::REQ_WRITE) &&
      (s_axis_tdata[brf_pkg::COUNT_W-1:0] == '0) |-> ##2
      m_axis_tvalid && !m_axis_tuser[0])
    else $error("zero-byte write not refused");

endmodule

bind byte_ring_fifo_multi_access brf_checker #(
  .CNT_W    (CNT_W),
  .M_DATA_W (M_DATA_W)
) u_brf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
